/* rtl/rtp_pkg.sv */
package rtp_pkg;

  localparam int FIELD_W    = 16;
  localparam int RADIUS_W   = 17;
  localparam int ANGLE_W    = 16;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN  = 24;
  localparam int ZW         = 24;
  localparam int T_W        = 14;

  localparam logic [ZW-1:0]      RIGHT_FINE  = ZW'(90 * 32768);
  localparam logic [ZW-1:0]      ROUND_HALF  = ZW'(128);
  localparam logic [T_W-1:0]     RIGHT_ANGLE = T_W'(90 * 128);
  localparam logic [ANGLE_W-1:0] HALF_TURN   = ANGLE_W'(180 * 128);
  localparam logic [ANGLE_W-1:0] FULL_TURN   = ANGLE_W'(360 * 128);

  // atan(2^-i) in 2^-15 degree
  localparam logic [ZW-1:0] ATAN_FINE [TABLE_LEN] = '{
    24'd1474560, 24'd870484, 24'd459940, 24'd233473,
    24'd117189,  24'd58652,  24'd29333,  24'd14667,
    24'd7334,    24'd3667,   24'd1833,   24'd917,
    24'd458,     24'd229,    24'd115,    24'd57,
    24'd29,      24'd14,     24'd7,      24'd4,
    24'd2,       24'd1,      24'd0,      24'd0
  };

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } ang_flags_t;

endpackage

/* rtl/rtp_cordic_cell.sv */
module rtp_cordic_cell
  import rtp_pkg::*;
#(
  parameter int W = 27,
  parameter int I = 0
) (
  input  logic                 clk_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [W-1:0]  dx, dy;
  logic signed [ZW-1:0] atan_s;
  logic signed [W-1:0]  x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic signed [W-1:0]  x_q, y_q;
  logic signed [ZW-1:0] z_q;

  assign dx     = y_i >>> I;
  assign dy     = x_i >>> I;
  assign atan_s = signed'(ATAN_FINE[I]);

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_s;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_s;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

/* rtl/rtp_root_cell.sv */
module rtp_root_cell #(
  parameter int RW = 17,
  parameter int K  = 0
) (
  input  logic            clk_i,
  input  logic [2*RW-1:0] s_i,
  input  logic [RW+2:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] s_o,
  output logic [RW+2:0]   rem_o,
  output logic [RW-1:0]   root_o
);

  logic [RW+2:0]   rem_sh, trial, rem_d;
  logic [RW-1:0]   root_d;
  logic            ge;
  logic [2*RW-1:0] s_q;
  logic [RW+2:0]   rem_q;
  logic [RW-1:0]   root_q;

  // remainder stays below 2^(RW+1), so the top two bits drop safely
  assign rem_sh = {rem_i[RW:0], s_i[2*K+1:2*K]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_d  = ge ? rem_sh - trial : rem_sh;
  assign root_d = {root_i[RW-2:0], ge};

  always_ff @(posedge clk_i) begin
    s_q    <= s_i;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign s_o    = s_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* rtl/rectangular_to_polar_top.sv */
// MB = min(MAGNITUDE_BITS, 16) and STEPS = min(ROTATION_STEPS, 24) size the
// radius path and the angle path.
// Throughput: one request per cycle; the root cells and the CORDIC cells run
// side by side, the shorter path padded. busy is never raised and the
// receiver cannot stall, so every accepted request gets its result on done_o, in order.
// Reset clears the valid line only; data registers are not reset.
module rectangular_to_polar_top
  import rtp_pkg::*;
#(
  parameter int ROTATION_STEPS = 16,
  parameter int MAGNITUDE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                x_negative_i,
  input  logic [FIELD_W-1:0]  x_magnitude_i,
  input  logic                y_negative_i,
  input  logic [FIELD_W-1:0]  y_magnitude_i,
  output logic                done_o,
  output logic [RADIUS_W-1:0] radius_o,
  output logic [ANGLE_W-1:0]  angle_o
);

  localparam int STEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
  localparam int MB    = (MAGNITUDE_BITS < FIELD_W) ? MAGNITUDE_BITS : FIELD_W;
  localparam int W     = MB + GUARD_BITS + 3;
  localparam int RW    = MB + 1;
  localparam int SW    = 2 * RW;
  localparam int LR    = RW + 3;
  localparam int LA    = STEPS + 2;
  localparam int D     = (LR > LA) ? LR : LA;
  localparam int RPAD  = D - LR;
  localparam int APAD  = D - LA;

  logic          acc;
  logic [MB-1:0] xm, ym;
  logic [D:1]    vld_q;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign xm   = x_magnitude_i[MB-1:0];
  assign ym   = y_magnitude_i[MB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[D-1:1], acc};
    end
  end

  assign done_o = vld_q[D];

  // radius path
  logic [2*MB-1:0] xsq_q, ysq_q;
  logic [SW-1:0]   s_c    [RW+1];
  logic [RW+2:0]   rem_c  [RW+1];
  logic [RW-1:0]   root_c [RW+1];
  logic [RW-1:0]   rad_d;
  logic [RADIUS_W-1:0] rad_q [RPAD+1];

  always_ff @(posedge clk_i) begin
    xsq_q <= {{MB{1'b0}}, xm} * {{MB{1'b0}}, xm};
    ysq_q <= {{MB{1'b0}}, ym} * {{MB{1'b0}}, ym};
    s_c[0] <= SW'(xsq_q) + SW'(ysq_q);
  end

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_root
    rtp_root_cell #(.RW(RW), .K(RW - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .s_i    (s_c[j]),
      .rem_i  (rem_c[j]),
      .root_i (root_c[j]),
      .s_o    (s_c[j+1]),
      .rem_o  (rem_c[j+1]),
      .root_o (root_c[j+1])
    );
  end

  // round to nearest: up when remainder exceeds the root
  assign rad_d = root_c[RW] + RW'(rem_c[RW] > (RW+3)'(root_c[RW]));

  always_ff @(posedge clk_i) begin
    rad_q[0] <= RADIUS_W'(rad_d);
    for (int i = 1; i <= RPAD; i++) begin
      rad_q[i] <= rad_q[i-1];
    end
  end

  assign radius_o = rad_q[RPAD];

  // angle path
  logic signed [W-1:0]  cx [STEPS+1];
  logic signed [W-1:0]  cy [STEPS+1];
  logic signed [ZW-1:0] cz [STEPS+1];
  ang_flags_t           flg_q [STEPS+1];
  ang_flags_t           flg_in, fl;
  logic [ZW-1:0]        zl, zc, zr;
  logic [T_W-1:0]       t;
  logic [ANGLE_W-1:0]   ang_f, ang_d;
  logic [ANGLE_W-1:0]   ang_q [APAD+1];

  assign flg_in.x_zero = (xm == '0);
  assign flg_in.y_zero = (ym == '0);
  assign flg_in.x_neg  = x_negative_i && !flg_in.x_zero;
  assign flg_in.y_neg  = y_negative_i && !flg_in.y_zero;

  always_ff @(posedge clk_i) begin
    cx[0]    <= signed'(W'({xm, {GUARD_BITS{1'b0}}}));
    cy[0]    <= signed'(W'({ym, {GUARD_BITS{1'b0}}}));
    cz[0]    <= '0;
    flg_q[0] <= flg_in;
    for (int k = 1; k <= STEPS; k++) begin
      flg_q[k] <= flg_q[k-1];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    rtp_cordic_cell #(.W(W), .I(i)) u_cell (
      .clk_i (clk_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  assign zl = cz[STEPS];
  assign fl = flg_q[STEPS];

  always_comb begin
    if (zl[ZW-1]) begin
      zc = '0;
    end else if (zl > RIGHT_FINE) begin
      zc = RIGHT_FINE;
    end else begin
      zc = zl;
    end
    zr = zc + ROUND_HALF;
    if (fl.y_zero) begin
      t = '0;
    end else if (fl.x_zero) begin
      t = RIGHT_ANGLE;
    end else begin
      t = zr[T_W+7:8];
    end
    case ({fl.x_neg, fl.y_neg})
      2'b00:   ang_f = ANGLE_W'(t);
      2'b10:   ang_f = HALF_TURN - ANGLE_W'(t);
      2'b11:   ang_f = HALF_TURN + ANGLE_W'(t);
      default: ang_f = FULL_TURN - ANGLE_W'(t);
    endcase
    ang_d = (ang_f >= FULL_TURN) ? ang_f - FULL_TURN : ang_f;
  end

  always_ff @(posedge clk_i) begin
    ang_q[0] <= ang_d;
    for (int i = 1; i <= APAD; i++) begin
      ang_q[i] <= ang_q[i-1];
    end
  end

  assign angle_o = ang_q[APAD];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##D done_o)
    else $error("result strobe missing after a request");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> angle_o < FULL_TURN)
    else $error("angle out of range");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && xm == '0 && ym == '0) |-> ##D (radius_o == '0 && angle_o == '0))
    else $error("origin not mapped to zero");

  a_pos_x_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ym == '0 && !x_negative_i) |-> ##D (angle_o == '0))
    else $error("positive x axis gives non-zero angle");

endmodule

/* test/rectangular_to_polar_top_tb.sv */
module rectangular_to_polar_top_tb;
  import rtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS_TB   = 16;
  localparam int MAG_BITS_TB = 16;
  localparam int STEPS_EFF  = (STEPS_TB < 24) ? STEPS_TB : 24;
  localparam int MAG_EFF    = (MAG_BITS_TB < 16) ? MAG_BITS_TB : 16;
  localparam int LATENCY    = (MAG_EFF + 4 > STEPS_EFF + 2) ? MAG_EFF + 4 : STEPS_EFF + 2;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 116;

  typedef struct {
    logic                xn;
    logic [FIELD_W-1:0]  xm;
    logic                yn;
    logic [FIELD_W-1:0]  ym;
    logic [RADIUS_W-1:0] radius;
    logic [ANGLE_W-1:0]  angle;
  } polar_req_t;

  class polar_checker;
    localparam longint QUARTER   = 90 * 128;
    localparam longint HALF      = 180 * 128;
    localparam longint FULL      = 360 * 128;
    localparam longint RIGHT_Z   = 90 * 32768;

    polar_req_t        pending_polar[$];
    int                mismatches;
    int                steps;
    longint unsigned   mag_mask;
    longint            atan_fine[24];

    function new(int rot_steps, int mag_bits);
      steps      = (rot_steps < 24) ? rot_steps : 24;
      mag_mask   = ((64'd1 << mag_bits) - 1) & 64'hFFFF;
      mismatches = 0;
      // atan(2^-i) in 2^-15 degree
      atan_fine  = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                     7334, 3667, 1833, 917, 458, 229, 115, 57,
                     29, 14, 7, 4, 2, 1, 0, 0};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void to_polar(input logic xn, input logic [FIELD_W-1:0] xm_in,
                           input logic yn, input logic [FIELD_W-1:0] ym_in,
                           output logic [RADIUS_W-1:0] rad,
                           output logic [ANGLE_W-1:0] ang);
      longint unsigned xm, ym, sq, root, cand;
      longint x, y, z, dx, dy, t, a;
      bit xneg, yneg;
      xm   = xm_in & mag_mask;
      ym   = ym_in & mag_mask;
      xneg = xn && (xm != 0);
      yneg = yn && (ym != 0);

      sq   = xm * xm + ym * ym;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= sq) root = cand;
      end
      if (sq - root * root > root) root++;
      rad = root[RADIUS_W-1:0];

      if (ym == 0) begin
        t = 0;
      end else if (xm == 0) begin
        t = QUARTER;
      end else begin
        x = xm << 8;
        y = ym << 8;
        z = 0;
        for (int i = 0; i < steps; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx;
            y -= dy;
            z += atan_fine[i];
          end else begin
            x -= dx;
            y += dy;
            z -= atan_fine[i];
          end
        end
        if (z < 0) z = 0;
        if (z > RIGHT_Z) z = RIGHT_Z;
        t = (z + 128) >>> 8;
      end

      if (!xneg && !yneg) a = t;
      else if (xneg && !yneg) a = HALF - t;
      else if (xneg && yneg) a = HALF + t;
      else a = FULL - t;
      if (a >= FULL) a -= FULL;
      ang = a[ANGLE_W-1:0];
    endfunction

    function void note_request(logic xn, logic [FIELD_W-1:0] xm,
                               logic yn, logic [FIELD_W-1:0] ym);
      polar_req_t r;
      r.xn = xn;
      r.xm = xm;
      r.yn = yn;
      r.ym = ym;
      to_polar(xn, xm, yn, ym, r.radius, r.angle);
      pending_polar.push_back(r);
    endfunction

    task check_result(logic [RADIUS_W-1:0] rad, logic [ANGLE_W-1:0] ang);
      polar_req_t r;
      if (pending_polar.size() == 0) begin
        report($sformatf("result with no request outstanding: radius %0d angle %0d",
                         rad, ang));
      end else begin
        r = pending_polar.pop_front();
        if (rad !== r.radius)
          report($sformatf("radius %0d, want %0d (x %0s%0d y %0s%0d)", rad, r.radius,
                           r.xn ? "-" : "+", r.xm, r.yn ? "-" : "+", r.ym));
        if (ang !== r.angle)
          report($sformatf("angle %0d, want %0d (x %0s%0d y %0s%0d)", ang, r.angle,
                           r.xn ? "-" : "+", r.xm, r.yn ? "-" : "+", r.ym));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                x_negative_i = 1'b0;
  logic [FIELD_W-1:0]  x_magnitude_i = '0;
  logic                y_negative_i = 1'b0;
  logic [FIELD_W-1:0]  y_magnitude_i = '0;
  logic                done_o;
  logic [RADIUS_W-1:0] radius_o;
  logic [ANGLE_W-1:0]  angle_o;

  polar_checker sb;
  int           quiet_cycles = 0;
  int           idle_pct [PHASES] = '{0, 58, 17, 58, 0, 17, 58, 0};

  rectangular_to_polar_top #(
    .ROTATION_STEPS(STEPS_TB),
    .MAGNITUDE_BITS(MAG_BITS_TB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .x_negative_i (x_negative_i),
    .x_magnitude_i(x_magnitude_i),
    .y_negative_i (y_negative_i),
    .y_magnitude_i(y_magnitude_i),
    .done_o       (done_o),
    .radius_o     (radius_o),
    .angle_o      (angle_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (start && busy === 1'b0 || done_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (start && busy === 1'b0)
        sb.note_request(x_negative_i, x_magnitude_i, y_negative_i, y_magnitude_i);
      if (done_o === 1'b1) sb.check_result(radius_o, angle_o);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task send_request(logic xn, logic [FIELD_W-1:0] xm, logic yn, logic [FIELD_W-1:0] ym,
                    int pct);
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    x_negative_i  <= xn;
    x_magnitude_i <= xm;
    y_negative_i  <= yn;
    y_magnitude_i <= ym;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // hold off until every outstanding request has its result
  task drain;
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_polar.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic               rxn, ryn;
    logic [FIELD_W-1:0] rxm, rym, tmp;
    int                 sel;
    sb = new(STEPS_TB, MAG_BITS_TB);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // origin, signed zeros, axes, corners, near-wrap
    send_request(1'b0, 16'd0, 1'b0, 16'd0, 0);
    send_request(1'b1, 16'd0, 1'b1, 16'd0, 0);
    send_request(1'b1, 16'd0, 1'b0, 16'd300, 0);
    send_request(1'b0, 16'd0, 1'b1, 16'd300, 0);
    send_request(1'b1, 16'd0, 1'b1, 16'hFFFF, 0);
    send_request(1'b0, 16'd500, 1'b1, 16'd0, 0);
    send_request(1'b1, 16'd500, 1'b1, 16'd0, 0);
    send_request(1'b1, 16'hFFFF, 1'b0, 16'd0, 0);
    send_request(1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 0);
    send_request(1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 0);
    send_request(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 0);
    send_request(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 0);
    send_request(1'b0, 16'd1, 1'b0, 16'd1, 0);
    send_request(1'b1, 16'd1, 1'b1, 16'd1, 0);
    send_request(1'b0, 16'hFFFF, 1'b1, 16'd1, 0);
    send_request(1'b1, 16'hFFFF, 1'b1, 16'd1, 0);
    send_request(1'b0, 16'd1, 1'b0, 16'hFFFF, 0);
    send_request(1'b1, 16'd1, 1'b0, 16'hFFFF, 0);
    send_request(1'b0, 16'h8000, 1'b1, 16'h7FFF, 0);
    send_request(1'b1, 16'h5555, 1'b0, 16'hAAAA, 0);
    send_request(1'b0, 16'd256, 1'b0, 16'd443, 0);
    send_request(1'b1, 16'd768, 1'b1, 16'd1024, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      repeat (PHASE_LEN) begin
        rxn = 1'($urandom_range(1));
        ryn = 1'($urandom_range(1));
        sel = $urandom_range(9);
        case (sel)
          0, 1, 2, 3: begin
            rxm = 16'($urandom);
            rym = 16'($urandom);
          end
          4, 5: begin
            rxm = 16'($urandom_range(255));
            rym = 16'($urandom_range(255));
          end
          6: begin
            rxm = 16'($urandom);
            rym = '0;
          end
          7: begin
            rxm = 16'($urandom_range(3));
            rym = 16'($urandom_range(3));
          end
          8: begin
            rxm = 16'($urandom);
            rym = rxm + 16'($urandom_range(7)) - 16'd3;
          end
          default: begin
            rxm = 16'($urandom_range(32768, 65535));
            rym = 16'($urandom_range(15));
          end
        endcase
        if (sel >= 6 && $urandom_range(1) == 1) begin
          tmp = rxm;
          rxm = rym;
          rym = tmp;
        end
        send_request(rxn, rxm, ryn, rym, idle_pct[p]);
      end
      drain();
    end

    repeat (LATENCY + 5) @(posedge clk_i);
    @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_polar.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
